[hw/rtl/lzrw_pkg.sv]
// shared types, constants and the preset pattern for the lz ring window decompressor
// no dependencies; imported by the control, top level and checker files
package lzrw_pkg;

   // window geometry
   localparam int WINDOW_DEPTH_DEF = 4096;
   localparam int PRESET_AW        = 12;
   localparam int COUNT_W          = 5;
   localparam int BYTE_W           = 8;

   // preset pattern region bounds
   localparam logic [PRESET_AW-1:0] PRESET_RAMP_END = 12'h100;
   localparam logic [PRESET_AW-1:0] PRESET_DOWN_END = 12'h200;
   localparam logic [PRESET_AW-1:0] PRESET_QUAD_END = 12'h600;

   // token parser phase
   typedef enum logic [1:0] {
      PH_CMD,
      PH_OFS,
      PH_LIT
   } phase_type;

   // sequencer state
   typedef enum logic {
      ST_ACCEPT,
      ST_COPY
   } state_type;

   // one output word handed from the control to the output register
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              last;
   } emit_type;

   // value of a window entry that was never written
   function automatic logic [BYTE_W-1:0] preset_value(input logic [PRESET_AW-1:0] a);
      logic [PRESET_AW-1:0] d;
      d = a - PRESET_DOWN_END;
      if (a < PRESET_RAMP_END) begin
         preset_value = a[BYTE_W-1:0];
      end else if (a < PRESET_DOWN_END) begin
         // 511 - a over this range is the inverted low byte
         preset_value = ~a[BYTE_W-1:0];
      end else if (a < PRESET_QUAD_END) begin
         preset_value = d[BYTE_W+1:2];
      end else begin
         preset_value = a[BYTE_W-1:0];
      end
   endfunction

endpackage

[hw/rtl/lzrw_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module lzrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lzrw_ctrl.sv]
// token parser and copy sequencer driving the window ram
// depends on lzrw_pkg
module lzrw_ctrl import lzrw_pkg::*; #(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [BYTE_W-1:0]               req_byte,
   input  logic                            req_last,
   input  logic                            preset_en,
   input  logic                            slot_free,
   output emit_type                        emit,
   output logic                            ram_wr_en,
   output logic [$clog2(WINDOW_DEPTH)-1:0] ram_wr_addr,
   output logic [BYTE_W-1:0]               ram_wr_data,
   output logic                            ram_rd_en,
   output logic [$clog2(WINDOW_DEPTH)-1:0] ram_rd_addr,
   input  logic [BYTE_W-1:0]               ram_rd_data
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int FW = AW + 1;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [3:0]           len_ff, len_in;
   logic [3:0]           ofs_hi_ff, ofs_hi_in;
   logic [COUNT_W-1:0]   lit_left_ff, lit_left_in;
   logic [AW-1:0]        wpos_ff, wpos_in;
   logic [FW-1:0]        fill_ff, fill_in;
   logic [AW-1:0]        rd_addr_ff, rd_addr_in;
   logic [COUNT_W-1:0]   issue_left_ff, issue_left_in;
   logic                 copy_last_ff, copy_last_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_fwd_ff, s1_fwd_in;
   logic [BYTE_W-1:0]    s1_fwd_data_ff, s1_fwd_data_in;
   logic                 s1_hit_ff, s1_hit_in;
   logic [AW-1:0]        s1_addr_ff, s1_addr_in;
   logic                 s1_final_ff, s1_final_in;

   logic                 req_accept;
   logic                 lit_push;
   logic                 s1_adv;
   logic                 issue;
   logic                 copy_done;
   logic                 push;
   logic [BYTE_W-1:0]    s1_byte;
   logic [BYTE_W-1:0]    push_data;

   assign req_accept = req_tvalid && req_tready;
   assign lit_push   = req_accept && (phase_ff == PH_LIT);
   assign s1_adv     = (state_ff == ST_COPY) && s1_valid_ff && slot_free;
   assign issue      = (state_ff == ST_COPY) && (issue_left_ff != '0)
                       && (!s1_valid_ff || s1_adv);
   assign copy_done  = s1_adv && s1_final_ff;
   assign push       = lit_push || s1_adv;
   assign push_data  = lit_push ? req_byte : s1_byte;

   // resolve the byte in the read stage: forwarded, stored, preset or zero
   always_comb begin
      if (s1_fwd_ff) begin
         s1_byte = s1_fwd_data_ff;
      end else if (s1_hit_ff) begin
         s1_byte = ram_rd_data;
      end else if (preset_en) begin
         s1_byte = preset_value(PRESET_AW'(s1_addr_ff));
      end else begin
         s1_byte = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCEPT: begin
            if (req_accept && (phase_ff == PH_OFS)) begin
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (copy_done) begin
               state_in = ST_ACCEPT;
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      unique case (state_ff)
         ST_ACCEPT: req_tready = (phase_ff != PH_LIT) || slot_free;
         ST_COPY:   req_tready = 1'b0;
         default:   req_tready = 1'b0;
      endcase
   end

   // ram ports and output word
   always_comb begin
      ram_wr_en   = push;
      ram_wr_addr = wpos_ff;
      ram_wr_data = push_data;
      ram_rd_en   = issue;
      ram_rd_addr = rd_addr_ff;
      emit.valid  = push;
      emit.data   = push_data;
      emit.last   = lit_push ? 1'b1 : s1_final_ff;
   end

   // parser, write pointer and read pipeline
   always_comb begin
      phase_in       = phase_ff;
      len_in         = len_ff;
      ofs_hi_in      = ofs_hi_ff;
      lit_left_in    = lit_left_ff;
      wpos_in        = wpos_ff;
      fill_in        = fill_ff;
      rd_addr_in     = rd_addr_ff;
      issue_left_in  = issue_left_ff;
      copy_last_in   = copy_last_ff;
      s1_valid_in    = s1_valid_ff;
      s1_fwd_in      = s1_fwd_ff;
      s1_fwd_data_in = s1_fwd_data_ff;
      s1_hit_in      = s1_hit_ff;
      s1_addr_in     = s1_addr_ff;
      s1_final_in    = s1_final_ff;

      // every stored byte advances the ring and the saturating fill count
      if (push) begin
         wpos_in = AW'(wpos_ff + 1'b1);
         if (fill_ff != FW'(WINDOW_DEPTH)) begin
            fill_in = fill_ff + 1'b1;
         end
      end

      // token parsing on each accepted word
      if (req_accept) begin
         case (phase_ff)
            PH_CMD: begin
               if (req_byte[7:4] != 4'h0) begin
                  len_in    = req_byte[7:4];
                  ofs_hi_in = req_byte[3:0];
                  phase_in  = PH_OFS;
               end else begin
                  lit_left_in = COUNT_W'(req_byte[3:0]) + 1'b1;
                  phase_in    = PH_LIT;
               end
            end
            PH_LIT: begin
               lit_left_in = lit_left_ff - 1'b1;
               if (lit_left_ff == COUNT_W'(1)) begin
                  phase_in = PH_CMD;
               end
            end
            PH_OFS: begin
               rd_addr_in    = AW'({ofs_hi_ff, req_byte});
               issue_left_in = COUNT_W'(len_ff) + COUNT_W'(2);
               copy_last_in  = req_last;
               phase_in      = PH_CMD;
            end
            default: phase_in = PH_CMD;
         endcase
      end

      // read issue, forwarding the byte written in the same cycle
      if (issue) begin
         s1_valid_in    = 1'b1;
         s1_fwd_in      = s1_adv && (rd_addr_ff == wpos_ff);
         s1_fwd_data_in = push_data;
         s1_hit_in      = ({1'b0, rd_addr_ff} < fill_ff);
         s1_addr_in     = rd_addr_ff;
         s1_final_in    = (issue_left_ff == COUNT_W'(1));
         rd_addr_in     = AW'(rd_addr_ff + 1'b1);
         issue_left_in  = issue_left_ff - 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      // end of stream returns the parser and ring to start
      if ((req_accept && req_last && (phase_ff != PH_OFS)) || (copy_done && copy_last_ff)) begin
         phase_in    = PH_CMD;
         len_in      = '0;
         ofs_hi_in   = '0;
         lit_left_in = '0;
         wpos_in     = '0;
         fill_in     = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_ACCEPT;
         phase_ff      <= PH_CMD;
         len_ff        <= '0;
         ofs_hi_ff     <= '0;
         lit_left_ff   <= '0;
         wpos_ff       <= '0;
         fill_ff       <= '0;
         issue_left_ff <= '0;
         copy_last_ff  <= 1'b0;
         s1_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         len_ff        <= len_in;
         ofs_hi_ff     <= ofs_hi_in;
         lit_left_ff   <= lit_left_in;
         wpos_ff       <= wpos_in;
         fill_ff       <= fill_in;
         issue_left_ff <= issue_left_in;
         copy_last_ff  <= copy_last_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      rd_addr_ff     <= rd_addr_in;
      s1_fwd_ff      <= s1_fwd_in;
      s1_fwd_data_ff <= s1_fwd_data_in;
      s1_hit_ff      <= s1_hit_in;
      s1_addr_ff     <= s1_addr_in;
      s1_final_ff    <= s1_final_in;
   end

endmodule

[hw/rtl/lz_ring_window_decompressor_unit.sv]
// lz ring window decompressor: command bytes are taken directly, literal bytes when the output slot is free;
// an offset byte starts a match of length n = L + 2 (accept, a window read per copied byte, drain)
// a copied byte passes the read stage and then the output register before rsp; the output register lets
// the next word be taken in the cycle its held result is accepted
// reset is synchronous; no clearing pass, unwritten entries are tracked by a fill count
// depends on lzrw_pkg, lzrw_ram, lzrw_ctrl
module lz_ring_window_decompressor_unit import lzrw_pkg::*; #(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] in_byte
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tlast,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   localparam int AW = $clog2(WINDOW_DEPTH);

   emit_type          emit;
   logic              slot_free;
   logic              preset_en_ff;
   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_data_ff;
   logic              out_last_ff;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   assign slot_free = !out_valid_ff || rsp_tready;

   // preset enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         preset_en_ff <= 1'b1;
      end else if (csr_wr_en) begin
         preset_en_ff <= csr_wr_data;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         out_data_ff <= emit.data;
         out_last_ff <= emit.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // parser and copy sequencer
   lzrw_ctrl #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_byte    (req_tdata),
      .req_last    (req_tlast),
      .preset_en   (preset_en_ff),
      .slot_free   (slot_free),
      .emit        (emit),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // history window
   lzrw_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

[hw/rtl/lzrw_checker.sv]
// port-level checks for the lz ring window decompressor, bound to the top level
// depends on lzrw_pkg and lz_ring_window_decompressor_unit
module lzrw_checker import lzrw_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [BYTE_W-1:0] rsp_tdata,
   input logic              rsp_tlast
);

   // after reset the parser waits for a command word and nothing is pending
   a_reset_clean: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("state not clean after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // mid-copy words block new input
   a_copy_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken while a copy is unfinished");

   // a copy streams without gaps once its words are taken
   a_copy_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a copy run");

endmodule

bind lz_ring_window_decompressor_unit lzrw_checker u_checker (.*);
